// ===== hdl/p2prf_pkg.sv =====
// ----------------------------------------------------------------------------
// p2prf_pkg: shared types, codes and functions
// Types, register indexes, command codes and the plane bit gather used by
// the packed 2bpp to planar rectangle flush unit.
// ----------------------------------------------------------------------------
package p2prf_pkg;

   typedef enum logic {
      CMD_RECT = 1'b0,
      CMD_DATA = 1'b1
   } command_type;

   typedef enum logic {
      KIND_SUMMARY = 1'b0,
      KIND_WRITE   = 1'b1
   } kind_type;

   typedef enum logic {
      PLANE_EVEN = 1'b0,
      PLANE_ODD  = 1'b1
   } plane_type;

   typedef enum logic [2:0] {
      REG_BOUND_MIN_X  = 3'd0,
      REG_BOUND_MIN_Y  = 3'd1,
      REG_BOUND_MAX_X  = 3'd2,
      REG_BOUND_MAX_Y  = 3'd3,
      REG_SCREEN_WIDTH = 3'd4
   } reg_index_type;

   localparam int CSR_ADDR_BITS = 5;

   localparam logic signed [15:0] BOUND_MIN_X_RESET  = 16'sd0;
   localparam logic signed [15:0] BOUND_MIN_Y_RESET  = 16'sd0;
   localparam logic signed [15:0] BOUND_MAX_X_RESET  = 16'sd640;
   localparam logic signed [15:0] BOUND_MAX_Y_RESET  = 16'sd480;
   localparam logic [11:0]        SCREEN_WIDTH_RESET = 12'd640;
   localparam logic [7:0]         STRIDE_RESET       = 8'd40;

   localparam logic [8:0]  WORDS_MAX = 9'd256;
   localparam logic [12:0] ROWS_MAX  = 13'd4096;

   typedef struct packed {
      logic signed [15:0] bound_min_x;
      logic signed [15:0] bound_min_y;
      logic signed [15:0] bound_max_x;
      logic signed [15:0] bound_max_y;
      logic [11:0]        screen_width_pixels;
   } cfg_type;

   typedef struct packed {
      command_type        command;
      logic signed [15:0] rect_min_x;
      logic signed [15:0] rect_min_y;
      logic signed [15:0] rect_max_x;
      logic signed [15:0] rect_max_y;
      logic [31:0]        packed_word;
   } req_type;

   // Clipped rectangle, ready for the walk stage.
   typedef struct packed {
      command_type command;
      logic        empty;
      logic [15:0] y0_rel;
      logic [11:0] first_word;
      logic [8:0]  words;
      logic [12:0] rows;
      logic [31:0] packed_word;
   } rect_type;

   typedef struct packed {
      kind_type    kind;
      logic        empty_res;
      logic [19:0] word_offset;
      logic [8:0]  words_in_row;
      logic [12:0] row_count;
      plane_type   plane;
      logic [15:0] plane_data;
      logic        last;
   } rsp_type;

   // One complemented plane byte from a 16-bit half; pixel zero lands in bit 7.
   function automatic logic [7:0] gather_byte(input logic [15:0] half, input logic odd);
      logic [7:0] b;
      for (int k = 0; k < 8; k++) begin
         b[7 - k] = half[2 * k + int'(odd)];
      end
      return ~b;
   endfunction

   function automatic logic [15:0] plane_word(input logic [31:0] v, input logic odd);
      return {gather_byte(v[31:16], odd), gather_byte(v[15:0], odd)};
   endfunction

endpackage

// ===== hdl/p2prf_channels.sv =====
// ----------------------------------------------------------------------------
// p2prf channels: request and response channel interfaces
// Valid/ready channels that carry rectangle commands and packed words in,
// and summaries and plane writes out.
// ----------------------------------------------------------------------------
interface p2prf_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic signed [15:0] rect_min_x;
   logic signed [15:0] rect_min_y;
   logic signed [15:0] rect_max_x;
   logic signed [15:0] rect_max_y;
   logic [31:0]        packed_word;

   modport source (output valid, command, rect_min_x, rect_min_y, rect_max_x, rect_max_y,
                   packed_word, input ready);
   modport sink (input valid, command, rect_min_x, rect_min_y, rect_max_x, rect_max_y,
                 packed_word, output ready);
endinterface

interface p2prf_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic        empty_res;
   logic [19:0] word_offset;
   logic [8:0]  words_in_row;
   logic [12:0] row_count;
   logic        plane;
   logic [15:0] plane_data;
   logic        last;

   modport source (output valid, kind, empty_res, word_offset, words_in_row, row_count,
                   plane, plane_data, last, input ready);
   modport sink (input valid, kind, empty_res, word_offset, words_in_row, row_count,
                 plane, plane_data, last, output ready);
endinterface

// ===== hdl/p2prf_csr.sv =====
// ----------------------------------------------------------------------------
// p2prf_csr: configuration registers
// APB-style register file holding the screen bounds and the screen width.
// ----------------------------------------------------------------------------
module p2prf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [p2prf_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output p2prf_pkg::cfg_type                  cfg
);

   p2prf_pkg::cfg_type       cfg_ff;
   p2prf_pkg::reg_index_type index;
   logic                     write_en;

   assign index    = p2prf_pkg::reg_index_type'(paddr[p2prf_pkg::CSR_ADDR_BITS-1:2]);
   assign write_en = psel & penable & pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bound_min_x         <= p2prf_pkg::BOUND_MIN_X_RESET;
         cfg_ff.bound_min_y         <= p2prf_pkg::BOUND_MIN_Y_RESET;
         cfg_ff.bound_max_x         <= p2prf_pkg::BOUND_MAX_X_RESET;
         cfg_ff.bound_max_y         <= p2prf_pkg::BOUND_MAX_Y_RESET;
         cfg_ff.screen_width_pixels <= p2prf_pkg::SCREEN_WIDTH_RESET;
      end else if (write_en) begin
         case (index)
            p2prf_pkg::REG_BOUND_MIN_X:  cfg_ff.bound_min_x         <= pwdata[15:0];
            p2prf_pkg::REG_BOUND_MIN_Y:  cfg_ff.bound_min_y         <= pwdata[15:0];
            p2prf_pkg::REG_BOUND_MAX_X:  cfg_ff.bound_max_x         <= pwdata[15:0];
            p2prf_pkg::REG_BOUND_MAX_Y:  cfg_ff.bound_max_y         <= pwdata[15:0];
            p2prf_pkg::REG_SCREEN_WIDTH: cfg_ff.screen_width_pixels <= pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         p2prf_pkg::REG_BOUND_MIN_X:  prdata = {16'b0, cfg_ff.bound_min_x};
         p2prf_pkg::REG_BOUND_MIN_Y:  prdata = {16'b0, cfg_ff.bound_min_y};
         p2prf_pkg::REG_BOUND_MAX_X:  prdata = {16'b0, cfg_ff.bound_max_x};
         p2prf_pkg::REG_BOUND_MAX_Y:  prdata = {16'b0, cfg_ff.bound_max_y};
         p2prf_pkg::REG_SCREEN_WIDTH: prdata = {20'b0, cfg_ff.screen_width_pixels};
         default:                     prdata = 32'b0;
      endcase
   end

endmodule

// ===== hdl/p2prf_clip.sv =====
// ----------------------------------------------------------------------------
// p2prf_clip: input register and rectangle clipping
// Registers each request transaction and clips a rectangle against the screen
// bounds, giving the start word, words per row and row count.
// ----------------------------------------------------------------------------
module p2prf_clip (
   input  logic                clock,
   input  logic                reset,
   p2prf_req_if.sink           req,
   input  p2prf_pkg::cfg_type  cfg,
   output logic                item_valid,
   output p2prf_pkg::rect_type item,
   input  logic                item_ready
);

   logic               in_valid_ff;
   p2prf_pkg::req_type req_ff;

   logic signed [15:0] x0, y0, x1, y1;
   logic [15:0]        x0_rel, x1_rel, y0_rel, y1_rel;
   logic [12:0]        end_word;
   logic [12:0]        word_span;
   logic [16:0]        row_span;

   assign req.ready  = ~in_valid_ff | item_ready;
   assign item_valid = in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready & req.valid) begin
         req_ff.command     <= p2prf_pkg::command_type'(req.command);
         req_ff.rect_min_x  <= req.rect_min_x;
         req_ff.rect_min_y  <= req.rect_min_y;
         req_ff.rect_max_x  <= req.rect_max_x;
         req_ff.rect_max_y  <= req.rect_max_y;
         req_ff.packed_word <= req.packed_word;
      end
   end

   always_comb begin
      x0 = (cfg.bound_min_x > req_ff.rect_min_x) ? cfg.bound_min_x : req_ff.rect_min_x;
      y0 = (cfg.bound_min_y > req_ff.rect_min_y) ? cfg.bound_min_y : req_ff.rect_min_y;
      x1 = (cfg.bound_max_x < req_ff.rect_max_x) ? cfg.bound_max_x : req_ff.rect_max_x;
      y1 = (cfg.bound_max_y < req_ff.rect_max_y) ? cfg.bound_max_y : req_ff.rect_max_y;

      // A non-empty clipped rectangle lies at or right of the bound origin,
      // so the 16-bit differences are exact.
      x0_rel = x0 - cfg.bound_min_x;
      x1_rel = x1 - cfg.bound_min_x;
      y0_rel = y0 - cfg.bound_min_y;
      y1_rel = y1 - cfg.bound_min_y;

      end_word  = {1'b0, x1_rel[15:4]} + {12'b0, |x1_rel[3:0]};
      word_span = end_word - {1'b0, x0_rel[15:4]};
      row_span  = {1'b0, y1_rel} - {1'b0, y0_rel} + 17'd1;

      item.command     = req_ff.command;
      item.empty       = (x1 < x0) | (y0 > y1);
      item.y0_rel      = y0_rel;
      item.first_word  = x0_rel[15:4];
      item.words       = (word_span > 13'(p2prf_pkg::WORDS_MAX)) ? p2prf_pkg::WORDS_MAX
                                                                 : word_span[8:0];
      item.rows        = (row_span > 17'(p2prf_pkg::ROWS_MAX)) ? p2prf_pkg::ROWS_MAX
                                                               : row_span[12:0];
      item.packed_word = req_ff.packed_word;
   end

endmodule

// ===== hdl/p2prf_walk.sv =====
// ----------------------------------------------------------------------------
// p2prf_walk: word walk and result register
// Holds the walk state, emits the rectangle summary, and turns each packed
// word that arrives during a walk into two plane writes through one result register.
// ----------------------------------------------------------------------------
module p2prf_walk #(
   parameter int OFFSET_BITS = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  p2prf_pkg::rect_type item,
   output logic                item_ready,
   input  logic [11:0]         screen_width_pixels,
   p2prf_rsp_if.source         rsp
);

   logic                  wk_valid_ff;
   p2prf_pkg::rect_type   wk_ff;
   logic                  half_ff;

   logic                  active_ff;
   logic [OFFSET_BITS-1:0] row_start_ff;
   logic [8:0]            column_ff;
   logic [12:0]           rows_left_ff;
   logic [8:0]            row_words_ff;
   logic [7:0]            stride_ff;

   logic                  out_valid_ff;
   p2prf_pkg::rsp_type    out_ff;

   logic                  out_free, is_rect, drop, emit, consume;
   logic [7:0]            stride_in;
   logic [23:0]           product;
   logic [24:0]           start_sum;
   logic [OFFSET_BITS-1:0] start_off;
   logic [OFFSET_BITS-1:0] write_off;
   logic [8:0]            column_in;
   logic                  row_end, fin, walk_in;
   logic [15:0]           plane_bits;

   always_comb begin
      out_free   = ~out_valid_ff | rsp.ready;
      is_rect    = (wk_ff.command == p2prf_pkg::CMD_RECT);
      drop       = wk_valid_ff & ~is_rect & ~active_ff;
      emit       = wk_valid_ff & out_free & (is_rect | active_ff);
      consume    = drop | (emit & (is_rect | half_ff));
      item_ready = ~wk_valid_ff | consume;

      stride_in  = screen_width_pixels[11:4];
      product    = wk_ff.y0_rel * stride_in;
      start_sum  = {1'b0, product} + 25'(wk_ff.first_word);
      start_off  = start_sum[OFFSET_BITS-1:0];
      walk_in    = ~wk_ff.empty & (wk_ff.words != 9'd0);

      write_off  = row_start_ff + OFFSET_BITS'(column_ff);
      column_in  = column_ff + 9'd1;
      row_end    = (column_in >= row_words_ff);
      fin        = row_end & (rows_left_ff == 13'd1);
      plane_bits = p2prf_pkg::plane_word(wk_ff.packed_word, half_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wk_valid_ff  <= 1'b0;
         half_ff      <= 1'b0;
         active_ff    <= 1'b0;
         row_start_ff <= '0;
         column_ff    <= 9'd0;
         rows_left_ff <= 13'd0;
         row_words_ff <= 9'd0;
         stride_ff    <= p2prf_pkg::STRIDE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         if (item_ready) begin
            wk_valid_ff <= item_valid;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (emit & is_rect) begin
            active_ff <= walk_in;
            if (~wk_ff.empty) begin
               row_start_ff <= start_off;
               column_ff    <= 9'd0;
               rows_left_ff <= wk_ff.rows;
               row_words_ff <= wk_ff.words;
               stride_ff    <= stride_in;
            end
         end else if (emit & ~half_ff) begin
            half_ff <= 1'b1;
         end else if (emit) begin
            half_ff <= 1'b0;
            if (row_end) begin
               column_ff    <= 9'd0;
               row_start_ff <= row_start_ff + OFFSET_BITS'(stride_ff);
               rows_left_ff <= rows_left_ff - 13'd1;
               if (rows_left_ff == 13'd1) begin
                  active_ff <= 1'b0;
               end
            end else begin
               column_ff <= column_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_ready & item_valid) begin
         wk_ff <= item;
      end
      if (emit & is_rect) begin
         out_ff.kind         <= p2prf_pkg::KIND_SUMMARY;
         out_ff.empty_res    <= wk_ff.empty;
         out_ff.word_offset  <= wk_ff.empty ? 20'd0 : 20'(start_off);
         out_ff.words_in_row <= wk_ff.empty ? 9'd0 : wk_ff.words;
         out_ff.row_count    <= wk_ff.empty ? 13'd0 : wk_ff.rows;
         out_ff.plane        <= p2prf_pkg::PLANE_EVEN;
         out_ff.plane_data   <= 16'd0;
         out_ff.last         <= ~walk_in;
      end else if (emit) begin
         out_ff.kind         <= p2prf_pkg::KIND_WRITE;
         out_ff.empty_res    <= 1'b0;
         out_ff.word_offset  <= 20'(write_off);
         out_ff.words_in_row <= 9'd0;
         out_ff.row_count    <= 13'd0;
         out_ff.plane        <= half_ff ? p2prf_pkg::PLANE_ODD : p2prf_pkg::PLANE_EVEN;
         out_ff.plane_data   <= plane_bits;
         out_ff.last         <= half_ff & fin;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.kind         = out_ff.kind;
   assign rsp.empty_res    = out_ff.empty_res;
   assign rsp.word_offset  = out_ff.word_offset;
   assign rsp.words_in_row = out_ff.words_in_row;
   assign rsp.row_count    = out_ff.row_count;
   assign rsp.plane        = out_ff.plane;
   assign rsp.plane_data   = out_ff.plane_data;
   assign rsp.last         = out_ff.last;

endmodule

// ===== hdl/packed_2bpp_to_planar_rect_flush_unit.sv =====
// ----------------------------------------------------------------------------
// packed_2bpp_to_planar_rect_flush_unit: packed 2bpp to planar flush walker
// Clips dirty rectangles to the screen, reports the word range to flush and
// converts each packed 2bpp word into two complemented bit-plane writes.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Carries
//   req_ch    in         valid/ready          rectangle command or packed word
//   rsp_ch    out        valid/ready          rectangle summary or plane write
//   csr       in/out     APB psel/penable     bounds and screen width registers
//
// Transactions are accepted when valid and ready are both high. Input, walk and
// result registers form the pipeline; a request passes through them in that order.
// A rectangle gives one result and a packed word two, one per plane write; the
// walk register holds a packed word until its second plane write is emitted.
// Synchronous reset empties the pipeline and restores 0, 0, 640, 480 and
// width 640. A response stall backs up into the walk and input registers.
// ----------------------------------------------------------------------------
module packed_2bpp_to_planar_rect_flush_unit #(
   parameter int OFFSET_BITS = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   p2prf_req_if.sink                           req_ch,
   p2prf_rsp_if.source                         rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [p2prf_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   // Live configuration from the register file. Software must change it only
   // while no transaction is in flight; the block does not enforce this.
   p2prf_pkg::cfg_type  cfg;

   // Clipped rectangle or packed word on its way from the clip stage to the
   // walk stage.
   logic                item_valid;
   logic                item_ready;
   p2prf_pkg::rect_type item;

   p2prf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The clip stage turns a rectangle into its start word, word count and
   // row count, all relative to the bound origin.
   p2prf_clip u_clip (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready)
   );

   // The walk stage keeps the current row start, column and rows left. A new
   // rectangle always abandons the walk in progress; packed words that arrive
   // with no walk active are dropped without a response.
   p2prf_walk #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_walk (
      .clock               (clock),
      .reset               (reset),
      .item_valid          (item_valid),
      .item                (item),
      .item_ready          (item_ready),
      .screen_width_pixels (cfg.screen_width_pixels),
      .rsp                 (rsp_ch)
   );

endmodule
